// ===== sv/blfp_pkg.sv =====
// Shared constants and types for the battery level filter.
package blfp_pkg;

  localparam int MV_W       = 16;
  localparam int PCT_W      = 7;
  localparam int WINDOW_LEN = 16;               // power of two: the mean is a shift
  localparam int WIN_LG2    = $clog2(WINDOW_LEN);
  localparam int SUM_W      = MV_W + WIN_LG2;
  localparam int CNT_W      = WIN_LG2 + 1;
  localparam int NUM_W      = MV_W + PCT_W;     // (v - min) * 100 fits here
  localparam int STEP_W     = $clog2(PCT_W);

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);
  localparam logic [PCT_W-1:0] PCT_ZERO = '0;

  localparam logic [MV_W-1:0] VBAT_MIN_RST = MV_W'(9000);
  localparam logic [MV_W-1:0] VBAT_MAX_RST = MV_W'(13800);

  // Configuration register indexes
  localparam logic REG_VBAT_MIN = 1'b0;
  localparam logic REG_VBAT_MAX = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } blfp_div_stat_t;

endpackage

// ===== sv/battery_level_filter_percent.sv =====
// Top level of the battery level filter with percent mapping.
// One in_ beat carries a millivolt sample. Until sixteen samples have been
// seen the sample itself is reported as filtered_mv with window_full low;
// from then on each sample replaces the oldest one in a sixteen-entry ring
// and the window mean (running sum shifted right by four) is reported with
// window_full high. The filtered voltage is also mapped to a whole percent
// between vbat_min_mv and vbat_max_mv, clamped to 0 and 100. After
// acceptance an item passes the read, map and output states when the percent
// clamps, and the divide state as well when it needs the quotient, which comes
// from a seven-step restoring divider that retires one quotient bit per cycle.
// in_ready is high only while the sequencer is idle; a finished result sits
// in the output register so the next sample can be taken before it drains.
// Write vbat_min_mv (index 0) and vbat_max_mv (index 1) only while idle.
module battery_level_filter_percent
  import blfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [MV_W-1:0]   cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MV_W-1:0]   in_sample_mv,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MV_W-1:0]   out_filtered_mv,
  output logic [PCT_W-1:0]  out_level_percent,
  output logic              out_window_full
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MAP  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [MV_W-1:0]    vmin_r, vmax_r;
  logic [MV_W-1:0]    ring [WINDOW_LEN];
  logic [MV_W-1:0]    rd_data_r;
  logic [MV_W-1:0]    samp_r;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [WIN_LG2-1:0] slot_r, slot_nxt;
  logic               full_r, full_nxt;
  logic [PCT_W-1:0]   pct_r, pct_nxt;
  logic               ring_we;
  logic               filling;
  logic [MV_W-1:0]    filt;
  logic [MV_W-1:0]    span_num;
  logic [NUM_W-1:0]   prod;
  logic               div_start;
  blfp_div_stat_t     div_stat;
  logic [PCT_W-1:0]   div_quo;
  logic               out_load;
  logic               out_valid_r;
  logic [MV_W-1:0]    out_mv_r;
  logic [PCT_W-1:0]   out_pct_r;
  logic               out_full_r;

  assign in_ready = (state_r == S_IDLE);
  assign filling  = (fill_r < CNT_W'(WINDOW_LEN));

  // filtered voltage: raw sample while filling, window mean after
  assign filt     = full_r ? sum_r[SUM_W-1:WIN_LG2] : samp_r;
  assign span_num = filt - vmin_r;
  assign prod     = NUM_W'(span_num) * NUM_W'(PCT_FULL);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vmin_r <= VBAT_MIN_RST;
      vmax_r <= VBAT_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VBAT_MIN: vmin_r <= cfg_wdata;
        REG_VBAT_MAX: vmax_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // sample ring: one registered read at the current slot, one write
  always_ff @(posedge clk) begin
    rd_data_r <= ring[slot_r];
    if (ring_we) begin
      ring[slot_r] <= samp_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    fill_nxt  = fill_r;
    slot_nxt  = slot_r;
    full_nxt  = full_r;
    pct_nxt   = pct_r;
    ring_we   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // update the running sum; drop the oldest sample once full
        ring_we  = 1'b1;
        slot_nxt = slot_r + WIN_LG2'(1);
        if (filling) begin
          sum_nxt  = sum_r + SUM_W'(samp_r);
          fill_nxt = fill_r + CNT_W'(1);
          full_nxt = 1'b0;
        end else begin
          sum_nxt  = sum_r - SUM_W'(rd_data_r) + SUM_W'(samp_r);
          full_nxt = 1'b1;
        end
        state_nxt = S_MAP;
      end
      S_MAP: begin
        priority if (filt >= vmax_r) begin
          pct_nxt   = PCT_FULL;
          state_nxt = S_OUT;
        end else if (filt <= vmin_r) begin
          pct_nxt   = PCT_ZERO;
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          pct_nxt   = div_quo;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r   <= '0;
      fill_r  <= '0;
      slot_r  <= '0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      fill_r  <= fill_nxt;
      slot_r  <= slot_nxt;
      full_r  <= full_nxt;
    end
    pct_r <= pct_nxt;
    if (in_valid && in_ready) begin
      samp_r <= in_sample_mv;
    end
  end

  blfp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod),
    .den   (vmax_r - vmin_r),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_mv_r   <= filt;
      out_pct_r  <= pct_r;
      out_full_r <= full_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_filtered_mv   = out_mv_r;
  assign out_level_percent = out_pct_r;
  assign out_window_full   = out_full_r;

endmodule

// ===== sv/blfp_div.sv =====
// Iterative restoring divider producing a quotient below 128.
module blfp_div
  import blfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_W-1:0]     num,
  input  logic [MV_W-1:0]      den,
  output blfp_div_stat_t       stat,
  output logic [PCT_W-1:0]     quo
);

  logic [NUM_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  dvs_r, dvs_nxt;
  logic [PCT_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              ge;

  // one compare-subtract per cycle while busy
  assign ge = (rem_r >= dvs_r);

  always_comb begin
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dvs_nxt  = NUM_W'(den) << (PCT_W - 1);
      quo_nxt  = '0;
      cnt_nxt  = STEP_W'(PCT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dvs_r;
      end
      quo_nxt = {quo_r[PCT_W-2:0], ge};
      dvs_nxt = dvs_r >> 1;
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

endmodule

// ===== sv/blfp_checker.sv =====
// Port-level checks for the battery level filter, bound to the top level.
module blfp_checker
  import blfp_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PCT_W-1:0] out_level_percent
);

  // a pending result beat stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before taken");

  // one sample at a time: ready drops right after acceptance
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken while busy");

  // percent never exceeds full scale
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level_percent <= PCT_FULL)
    else $error("percent above full scale");

  // reset leaves no result pending
  a_rst_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind battery_level_filter_percent blfp_checker u_blfp_checker (.*);

// ===== dv/tb_top.sv =====
// Testbench for the battery level filter: directed and random samples checked against a window predictor.
module tb_top;
  import blfp_pkg::*;

  localparam int STALL_MAX      = 18;    // longest idle burst on either side
  localparam int SETTLE_CYCLES  = 24;    // settle time after draining
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat and no register write
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic [MV_W-1:0]  filtered_mv;
    logic [PCT_W-1:0] level_percent;
    logic             window_full;
  } level_result_t;

  // Drive every input to a known value from time zero.
  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              cfg_we       = 1'b0;
  logic              cfg_index    = REG_VBAT_MIN;
  logic [MV_W-1:0]   cfg_wdata    = '0;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [MV_W-1:0]   in_sample_mv = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [MV_W-1:0]   out_filtered_mv;
  logic [PCT_W-1:0]  out_level_percent;
  logic              out_window_full;

  battery_level_filter_percent dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample_mv      (in_sample_mv),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_filtered_mv   (out_filtered_mv),
    .out_level_percent (out_level_percent),
    .out_window_full   (out_window_full)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor state: the sample window and the thresholds as the block holds them.
  logic [MV_W-1:0]    ring_mv [WINDOW_LEN];
  logic [CNT_W-1:0]   fill_cnt     = '0;
  logic [WIN_LG2-1:0] slot_ptr     = '0;
  logic [SUM_W-1:0]   sum_mv       = '0;
  logic [MV_W-1:0]    vbat_min_set = VBAT_MIN_RST;
  logic [MV_W-1:0]    vbat_max_set = VBAT_MAX_RST;

  logic [MV_W-1:0] sample_q [$];        // samples waiting for the driver
  level_result_t   level_expect_q [$];  // predicted result beats, oldest first

  logic sender_hold = 1'b0;
  logic idle_on     = 1'b0;
  int   send_gap    = 0;
  int   recv_stall  = 0;
  int   mismatches  = 0;
  int   quiet_cycles = 0;

  // Map a filtered voltage to whole percent; the max test wins when min >= max.
  function automatic logic [PCT_W-1:0] percent_of(input logic [MV_W-1:0] v);
    if (v >= vbat_max_set) return PCT_FULL;
    if (v <= vbat_min_set) return PCT_ZERO;
    return PCT_W'(((32'(v) - 32'(vbat_min_set)) * 32'd100) /
                  (32'(vbat_max_set) - 32'(vbat_min_set)));
  endfunction

  // Advance the window by one sample and queue the beat it must produce.
  task automatic predict_level(input logic [MV_W-1:0] s);
    level_result_t r;
    if (fill_cnt < WINDOW_LEN) begin
      // still filling: pass the raw sample through
      fill_cnt      = fill_cnt + 1'b1;
      sum_mv        = sum_mv + SUM_W'(s);
      r.filtered_mv = s;
      r.window_full = 1'b0;
    end else begin
      // full: the write slot holds the oldest sample, swap it out of the sum
      sum_mv        = sum_mv - SUM_W'(ring_mv[slot_ptr]) + SUM_W'(s);
      r.filtered_mv = MV_W'(sum_mv >> WIN_LG2);
      r.window_full = 1'b1;
    end
    ring_mv[slot_ptr] = s;
    slot_ptr          = slot_ptr + 1'b1;
    r.level_percent   = percent_of(r.filtered_mv);
    level_expect_q    = {level_expect_q, r};
  endtask

  // Driver: predict on every accepted beat, hold valid until accepted,
  // then either idle for a burst or present the next pending sample.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_level(in_sample_mv);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0 && !sender_hold) begin
          in_valid     <= 1'b1;
          in_sample_mv <= sample_q.pop_front();
          if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, STALL_MAX);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction, then
  // decide out_ready for the next cycle (random stall bursts while idling).
  always @(posedge clk) begin : result_monitor
    level_result_t got;
    level_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_filtered_mv, out_level_percent, out_window_full};
        if (level_expect_q.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result beat: filtered_mv=%0d level_percent=%0d window_full=%0b",
                     got.filtered_mv, got.level_percent, got.window_full);
        end else begin
          want = level_expect_q.pop_front();
          if (got.filtered_mv !== want.filtered_mv ||
              got.level_percent !== want.level_percent ||
              got.window_full !== want.window_full) begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_MAX)
              $display({"result mismatch: filtered_mv exp %0d got %0d, ",
                        "level_percent exp %0d got %0d, window_full exp %0b got %0b"},
                       want.filtered_mv, got.filtered_mv, want.level_percent,
                       got.level_percent, want.window_full, got.window_full);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(0, STALL_MAX - 1);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: stop a run that no longer moves.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int clamp_mv(input int v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  // Queue n samples: some fully random, some constant runs at the rails
  // (drives the sum to its extremes), most in clusters centred inside [lo, hi]
  // so the window mean wanders across the whole percent scale.
  task automatic queue_random(input int n, input int lo, input int hi);
    int left;
    int pick;
    int run_len;
    int center;
    logic [MV_W-1:0] run_mv;
    left = n;
    while (left > 0) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        run_len = $urandom_range(16, 20);
        run_mv  = $urandom_range(0, 1) ? '1 : '0;
        repeat (run_len) sample_q = {sample_q, run_mv};
        left = left - run_len;
      end else if (pick < 6) begin
        sample_q = {sample_q, MV_W'($urandom)};
        left = left - 1;
      end else begin
        center  = $urandom_range(lo, hi);
        run_len = $urandom_range(4, 24);
        repeat (run_len)
          sample_q = {sample_q, MV_W'(clamp_mv(center + $urandom_range(0, 128) - 64))};
        left = left - run_len;
      end
    end
  endtask

  // Wait until every sample is sent and every result has come, then let the
  // block settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_valid || level_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [MV_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_VBAT_MIN) vbat_min_set = value;
    else vbat_max_set = value;
  endtask

  // Drain, reprogram both thresholds, then queue random samples around them.
  task automatic run_phase(input int min_mv, input int max_mv, input int n, input logic idle);
    int lo;
    int hi;
    wait_drained();
    write_reg(REG_VBAT_MIN, MV_W'(min_mv));
    write_reg(REG_VBAT_MAX, MV_W'(max_mv));
    idle_on <= idle;
    lo = clamp_mv(((min_mv < max_mv) ? min_mv : max_mv) - 300);
    hi = clamp_mv(((min_mv < max_mv) ? max_mv : min_mv) + 300);
    queue_random(n, lo, hi);
  endtask

  initial begin
    int m;
    repeat (12) @(posedge clk);
    rst_n   <= 1'b1;
    idle_on <= 1'b1;

    // Directed, reset thresholds: fill with rails and threshold neighbors,
    // then push four samples each of the top and bottom rails.
    sample_q = '{16'd0, 16'd65535, 16'd9000, 16'd8999, 16'd9001, 16'd13800,
                 16'd13799, 16'd13801, 16'd11400, 16'h5555, 16'hAAAA, 16'd1,
                 16'd65534, 16'd12000, 16'd10000, 16'd13000,
                 16'd65535, 16'd65535, 16'd65535, 16'd65535,
                 16'd0, 16'd0, 16'd0, 16'd0};
    queue_random(280, 8700, 14100);

    // Hold the sender once mid-stream until every result has drained.
    while (sample_q.size() > 140) @(negedge clk);
    sender_hold <= 1'b1;
    do @(negedge clk);
    while (in_valid || level_expect_q.size() != 0);
    @(posedge clk);
    sender_hold <= 1'b0;

    run_phase(0, 65535, 220, 1'b1);     // widest span
    run_phase(12000, 12000, 150, 1'b0); // min equal to max: only 0 or 100
    run_phase(20000, 5000, 150, 1'b1);  // min above max
    run_phase(65535, 0, 100, 1'b1);     // thresholds at opposite rails
    run_phase(11000, 11001, 100, 1'b1); // span of one millivolt
    m = $urandom_range(0, 60000);
    run_phase(m, m + $urandom_range(2, 5535), 200, 1'b1);
    run_phase(int'(VBAT_MIN_RST), int'(VBAT_MAX_RST), 150, 1'b0); // reset values, no idling

    wait_drained();
    if (mismatches == 0 && level_expect_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== battery_level_filter_percent.f =====
sv/blfp_pkg.sv
sv/blfp_div.sv
sv/battery_level_filter_percent.sv
sv/blfp_checker.sv
dv/tb_top.sv
